/* design/fnve_pkg.sv */
// Package for the flat-normal vertex expander: widths and shared types.
// Used by all modules of the block; depends on nothing.
package fnve_pkg;

  localparam int POS_WIDTH_DEF        = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int PW                   = 24;   // port width of positions
  localparam int NW                   = 16;   // port width of normals
  localparam int TW                   = 32;   // texture word width
  localparam int IW                   = 32;   // vertex index width
  localparam int DW                   = 25;   // difference width after pre-shift
  localparam int CW                   = 51;   // cross product component width
  localparam int MW                   = 50;   // cross product magnitude width

  // One triangle as held between front and back
  typedef struct packed {
    logic [2:0][PW-1:0] x;
    logic [2:0][PW-1:0] y;
    logic [2:0][PW-1:0] z;
    logic [2:0][TW-1:0] u;
    logic [2:0][TW-1:0] v;
    logic [IW-1:0]      base;
  } tri_t;

endpackage

/* design/flat_normal_vertex_expander.sv */
// Top level of the flat-normal vertex expander.
// Depends on fnve_pkg, fnve_front and fnve_back.
//
// Takes one triangle corner per item and emits three vertices per triangle sharing
// the Q2.14 face normal. The first two corners of a triangle are held in the front;
// after the third is taken the back computes the normal by a serial normalizing
// shift, a bit-serial square root and three bit-serial divisions; a degenerate
// triangle skips the square root and divisions. The three vertices
// then leave one per cycle while pop is high. The front keeps collecting the next
// triangle's corners while the back works, with one triangle buffered between them;
// once that buffer is filled, full stays high until the back is idle again.
module flat_normal_vertex_expander #(
  parameter int POS_WIDTH        = fnve_pkg::POS_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = fnve_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tex_enable_we,
  input  logic                    tex_enable_wdata,
  input  logic                    push,
  output logic                    full,
  input  logic [fnve_pkg::PW-1:0] corner_x,
  input  logic [fnve_pkg::PW-1:0] corner_y,
  input  logic [fnve_pkg::PW-1:0] corner_z,
  input  logic [fnve_pkg::TW-1:0] corner_u,
  input  logic [fnve_pkg::TW-1:0] corner_v,
  input  logic                    start_req,
  output logic                    empty,
  input  logic                    pop,
  output logic [fnve_pkg::PW-1:0] vert_x,
  output logic [fnve_pkg::PW-1:0] vert_y,
  output logic [fnve_pkg::PW-1:0] vert_z,
  output logic [fnve_pkg::NW-1:0] normal_x,
  output logic [fnve_pkg::NW-1:0] normal_y,
  output logic [fnve_pkg::NW-1:0] normal_z,
  output logic [fnve_pkg::TW-1:0] vert_u,
  output logic [fnve_pkg::TW-1:0] vert_v,
  output logic [fnve_pkg::IW-1:0] vertex_index,
  output logic                    last
);

  logic           tex_enable;
  logic           in_ready;
  logic           tri_valid;
  logic           tri_ready;
  fnve_pkg::tri_t tri_q;

  // config register
  always_ff @(posedge clk) begin
    if (rst) tex_enable <= 1'b0;
    else if (tex_enable_we) tex_enable <= tex_enable_wdata;
  end

  assign full = !in_ready;

  fnve_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_ready(in_ready),
    .cx(corner_x), .cy(corner_y), .cz(corner_z), .cu(corner_u), .cv(corner_v),
    .start(start_req), .tri_valid(tri_valid), .tri_ready(tri_ready), .tri_out(tri_q)
  );

  fnve_back #(.POS_WIDTH(POS_WIDTH), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .tex_enable(tex_enable),
    .tri_valid(tri_valid), .tri_ready(tri_ready), .tri_in(tri_q),
    .empty(empty), .pop(pop),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .vert_u(vert_u), .vert_v(vert_v), .vertex_index(vertex_index), .last(last)
  );

endmodule

/* design/fnve_front.sv */
// Front part: collects corners, handles start requests, hands out whole triangles.
// Depends on fnve_pkg.
module fnve_front #(
  parameter int POS_WIDTH = fnve_pkg::POS_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [fnve_pkg::PW-1:0] cx,
  input  logic [fnve_pkg::PW-1:0] cy,
  input  logic [fnve_pkg::PW-1:0] cz,
  input  logic [fnve_pkg::TW-1:0] cu,
  input  logic [fnve_pkg::TW-1:0] cv,
  input  logic                    start,
  output logic                    tri_valid,
  input  logic                    tri_ready,
  output fnve_pkg::tri_t          tri_out
);

  logic [1:0][fnve_pkg::PW-1:0] hx, hy, hz;
  logic [1:0][fnve_pkg::TW-1:0] hu, hv;
  logic [1:0]                   count;
  logic [fnve_pkg::IW-1:0]      next_index;
  logic [1:0]                   slot;
  logic [fnve_pkg::IW-1:0]      idx;
  logic                         acc;

  // sign-extend from POS_WIDTH bits
  function automatic logic [fnve_pkg::PW-1:0] sx(input logic [fnve_pkg::PW-1:0] a);
    logic [fnve_pkg::PW-1:0] r;
    r = a;
    if (POS_WIDTH < fnve_pkg::PW) begin
      for (int i = 0; i < fnve_pkg::PW; i++) begin
        if (i >= POS_WIDTH) r[i] = a[POS_WIDTH-1];
      end
    end
    return r;
  endfunction

  assign in_ready = !tri_valid || tri_ready;
  assign acc      = in_valid && in_ready;
  assign slot     = start ? 2'd0 : count;
  assign idx      = start ? '0 : next_index;

  // corner collection
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_index <= '0;
      tri_valid  <= 1'b0;
    end else begin
      if (tri_ready) tri_valid <= 1'b0;
      if (acc) begin
        if (slot == 2'd2) begin
          count      <= '0;
          next_index <= idx + fnve_pkg::IW'(3);
          tri_valid  <= 1'b1;
        end else begin
          count      <= slot + 2'd1;
          next_index <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (slot == 2'd2) begin
        tri_out.x    <= {sx(cx), hx[1], hx[0]};
        tri_out.y    <= {sx(cy), hy[1], hy[0]};
        tri_out.z    <= {sx(cz), hz[1], hz[0]};
        tri_out.u    <= {cu, hu[1], hu[0]};
        tri_out.v    <= {cv, hv[1], hv[0]};
        tri_out.base <= idx;
      end else begin
        hx[slot[0]] <= sx(cx);
        hy[slot[0]] <= sx(cy);
        hz[slot[0]] <= sx(cz);
        hu[slot[0]] <= cu;
        hv[slot[0]] <= cv;
      end
    end
  end

endmodule

/* design/fnve_back.sv */
// Back part: face normal sequencer (cross product, normalize, sqrt, divide)
// and vertex emission. Depends on fnve_pkg.
module fnve_back #(
  parameter int POS_WIDTH        = fnve_pkg::POS_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = fnve_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tex_enable,
  input  logic                    tri_valid,
  output logic                    tri_ready,
  input  fnve_pkg::tri_t          tri_in,
  output logic                    empty,
  input  logic                    pop,
  output logic [fnve_pkg::PW-1:0] vert_x,
  output logic [fnve_pkg::PW-1:0] vert_y,
  output logic [fnve_pkg::PW-1:0] vert_z,
  output logic [fnve_pkg::NW-1:0] normal_x,
  output logic [fnve_pkg::NW-1:0] normal_y,
  output logic [fnve_pkg::NW-1:0] normal_z,
  output logic [fnve_pkg::TW-1:0] vert_u,
  output logic [fnve_pkg::TW-1:0] vert_v,
  output logic [fnve_pkg::IW-1:0] vertex_index,
  output logic                    last
);

  localparam int PRE  = (POS_WIDTH > 24) ? POS_WIDTH - 24 : 0;
  localparam int QW   = 31 + NORMAL_FRAC_BITS;   // dividend width
  localparam int SW   = 62;                      // sum of squares width
  localparam int RW   = 31;                      // root width

  localparam logic [3:0] S_IDLE = 4'd0, S_DIFF = 4'd1, S_MUL = 4'd2, S_CROSS = 4'd3,
                         S_NORM = 4'd4, S_SQ = 4'd5, S_SQRT = 4'd6, S_DIV = 4'd7,
                         S_OUT = 4'd8;

  logic [3:0]                      state;
  fnve_pkg::tri_t                  t;
  logic signed [2:0][fnve_pkg::DW-1:0] du, dv;
  logic signed [5:0][2*fnve_pkg::DW-1:0] pr;
  logic [2:0]                      neg;
  logic [2:0][fnve_pkg::MW-1:0]    m;
  logic [2:0]                      k;          // step counter
  logic [SW-1:0]                   sq_acc, rem;
  logic [RW-1:0]                   root;
  logic [5:0]                      sq_step;
  logic [1:0]                      comp;
  logic [QW-1:0]                   dividend;
  logic [QW-1:0]                   quot;
  logic [6:0]                      dstep;
  logic [RW:0]                     drem;
  logic [2:0][fnve_pkg::NW-1:0]    nrm;
  logic [1:0]                      vk;
  logic                            degen;

  // difference with pre-shift toward zero
  function automatic logic signed [fnve_pkg::DW-1:0] dif(input logic [fnve_pkg::PW-1:0] a,
                                                         input logic [fnve_pkg::PW-1:0] b);
    logic signed [fnve_pkg::PW:0] d;
    logic [fnve_pkg::PW:0] mg;
    d  = $signed({a[fnve_pkg::PW-1], a}) - $signed({b[fnve_pkg::PW-1], b});
    mg = d[fnve_pkg::PW] ? fnve_pkg::DW'(0) - d : d;
    mg = mg >> PRE;
    return d[fnve_pkg::PW] ? fnve_pkg::DW'(0) - fnve_pkg::DW'(mg) : fnve_pkg::DW'(mg);
  endfunction

  logic signed [fnve_pkg::CW-1:0] cr;
  logic [fnve_pkg::MW-1:0]        big;
  logic [RW:0]                    trial;
  logic [SW-1:0]                  sq_try;
  logic [fnve_pkg::NW-1:0]        qcap;
  logic [QW-1:0]                  one;

  always_comb begin
    cr  = $signed({pr[2*k[1:0]][2*fnve_pkg::DW-1], pr[2*k[1:0]]})
        - $signed({pr[2*k[1:0]+1][2*fnve_pkg::DW-1], pr[2*k[1:0]+1]});
    big = m[0] | m[1] | m[2];
    sq_try = rem;
    trial  = {drem[RW-1:0], dividend[QW-1]};
    one    = QW'(1) << NORMAL_FRAC_BITS;
    qcap   = (quot > one) ? fnve_pkg::NW'(one) : fnve_pkg::NW'(quot);
  end

  assign tri_ready = (state == S_IDLE);
  assign empty     = (state != S_OUT);
  assign vert_x    = t.x[vk];
  assign vert_y    = t.y[vk];
  assign vert_z    = t.z[vk];
  assign vert_u    = tex_enable ? t.u[vk] : '0;
  assign vert_v    = tex_enable ? t.v[vk] : '0;
  assign normal_x  = nrm[0];
  assign normal_y  = nrm[1];
  assign normal_z  = nrm[2];
  assign vertex_index = t.base + fnve_pkg::IW'(vk);
  assign last      = (vk == 2'd2);

  // normal sequencer: cross-product multiplies, bit-serial sqrt and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (tri_valid) begin
            t     <= tri_in;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            du[i] <= dif(i == 0 ? t.x[1] : i == 1 ? t.y[1] : t.z[1],
                         i == 0 ? t.x[0] : i == 1 ? t.y[0] : t.z[0]);
            dv[i] <= dif(i == 0 ? t.x[2] : i == 1 ? t.y[2] : t.z[2],
                         i == 0 ? t.x[0] : i == 1 ? t.y[0] : t.z[0]);
          end
          k     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // products for component k: (a1*b2, a2*b1) with rotating axes
          case (k)
            3'd0: begin
              pr[0] <= $signed(du[1]) * $signed(dv[2]);
              pr[1] <= $signed(du[2]) * $signed(dv[1]);
            end
            3'd1: begin
              pr[2] <= $signed(du[2]) * $signed(dv[0]);
              pr[3] <= $signed(du[0]) * $signed(dv[2]);
            end
            default: begin
              pr[4] <= $signed(du[0]) * $signed(dv[1]);
              pr[5] <= $signed(du[1]) * $signed(dv[0]);
            end
          endcase
          if (k == 3'd2) begin
            k     <= '0;
            state <= S_CROSS;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_CROSS: begin
          neg[k[1:0]] <= cr[fnve_pkg::CW-1];
          m[k[1:0]]   <= cr[fnve_pkg::CW-1] ? fnve_pkg::MW'(-cr) : fnve_pkg::MW'(cr);
          if (k == 3'd2) begin
            state <= S_NORM;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_NORM: begin
          // shift magnitudes one bit a cycle until the largest is in [2^29, 2^30)
          if (big == '0) begin
            degen <= 1'b1;
            state <= S_SQ;
            k     <= '0;
          end else if (big[fnve_pkg::MW-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!big[29]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            degen  <= 1'b0;
            sq_acc <= '0;
            k      <= '0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          if (degen) begin
            nrm   <= {fnve_pkg::NW'(0), fnve_pkg::NW'(one), fnve_pkg::NW'(0)};
            vk    <= '0;
            state <= S_OUT;
          end else if (k == 3'd3) begin
            rem     <= sq_acc;
            root    <= '0;
            sq_step <= 6'd31;
            state   <= S_SQRT;
          end else begin
            sq_acc <= sq_acc + SW'(m[k[1:0]][29:0] * m[k[1:0]][29:0]);
            k      <= k + 3'd1;
          end
        end
        S_SQRT: begin
          // restoring square root, one result bit per cycle
          if ((SW'(root) << (sq_step[4:0]+1) | (SW'(1) << (2*sq_step[4:0])))
              <= sq_try && sq_step != 6'd31) begin
            rem  <= rem - ((SW'(root) << (sq_step[4:0]+1)) | (SW'(1) << (2*sq_step[4:0])));
            root <= root | (RW'(1) << sq_step[4:0]);
          end
          if (sq_step == 6'd0) begin
            comp  <= '0;
            state <= S_DIV;
            dstep <= '0;
            drem  <= '0;
          end else begin
            sq_step <= sq_step - 6'd1;
          end
          if (sq_step == 6'd31) sq_step <= 6'd30;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (dstep == 7'd0) begin
            dividend <= (QW'(m[comp][29:0]) << NORMAL_FRAC_BITS) + QW'(root >> 1);
            drem     <= '0;
            quot     <= '0;
            dstep    <= 7'd1;
          end else if (dstep <= 7'(QW)) begin
            dividend <= dividend << 1;
            if (trial >= {1'b0, root}) begin
              drem <= trial - {1'b0, root};
              quot <= {quot[QW-2:0], 1'b1};
            end else begin
              drem <= trial;
              quot <= {quot[QW-2:0], 1'b0};
            end
            dstep <= dstep + 7'd1;
          end else begin
            nrm[comp] <= neg[comp] ? fnve_pkg::NW'(0) - qcap : qcap;
            dstep     <= '0;
            if (comp == 2'd2) begin
              vk    <= '0;
              state <= S_OUT;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (pop) begin
            if (vk == 2'd2) state <= S_IDLE;
            vk <= vk + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
